[rtl/phb_pkg.sv]
// Shared types and constants for the peak-hold bar graph.
`timescale 1ns / 1ps
`default_nettype none

package phb_pkg;

    // Field widths
    localparam int LEVEL_W  = 16;
    localparam int ROW_W    = 6;
    localparam int HGT_W    = 7;
    localparam int HUE_W    = 8;
    localparam int PERIOD_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH    = 2'd3;

    // Register reset values
    localparam logic [HGT_W-1:0]    FULL_SCALE_RST  = 7'd16;
    localparam logic [PERIOD_W-1:0] FALL_PERIOD_RST = 8'd8;
    localparam logic [HUE_W-1:0]    HUE_LOW_RST     = 8'd0;
    localparam logic [HUE_W-1:0]    HUE_HIGH_RST    = 8'd128;

    // Smallest held peak that shows a dot is one above this
    localparam logic [HGT_W-1:0] DOT_MIN = 7'd3;

    // Input beat
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] floor_level;
        logic [LEVEL_W-1:0] ceiling_level;
    } t_in_beat;

    // Output beat, one per LED row
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             lit;
        logic [HUE_W-1:0] hue;
        logic             peak_dot;
        logic [HGT_W-1:0] bar_height;
        logic [HGT_W-1:0] held_peak;
        logic             last_row;
    } t_out_beat;

endpackage

`default_nettype wire

[rtl/phb_if.sv]
// Valid/ready channel interfaces for the input and output beats.
`timescale 1ns / 1ps
`default_nettype none

interface phb_in_if
    import phb_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface phb_out_if
    import phb_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/peak_hold_bar_graph.sv]
// Peak-hold bar graph: level scaling, falling peak and per-row LED beats.
// Sequence: the input beat passes through magnitude, bit-serial multiply, serial restoring
// divide and peak steps, then the output register holds the first row beat.
// A new input beat is taken only after the last row beat of the previous one is loaded;
// the row beats follow at one row beat per cycle while the sink is ready.
// Reset: synchronous, active low; registers return to defaults, peak and fall counter to 0.
`timescale 1ns / 1ps
`default_nettype none

module peak_hold_bar_graph
    import phb_pkg::*;
#(
    parameter int ROWS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    phb_in_if.sink                i_in,
    phb_out_if.source             o_out
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] DEN      = ROW_W'(ROWS - 1);
    localparam logic [HGT_W-1:0] ROWS_H   = HGT_W'(ROWS);

    localparam int DIFF_W = LEVEL_W + 1;
    localparam int ACC_W  = LEVEL_W + HGT_W;
    localparam int DSH_W  = LEVEL_W + HGT_W - 1;

    // Sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ABS  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PEAK = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    localparam logic [2:0] MUL_LAST = 3'd7;
    localparam logic [2:0] DIV_LAST = 3'd6;

    logic [2:0] r_state;
    logic [2:0] r_cnt;

    // Configuration
    logic [HGT_W-1:0]    r_full_scale;
    logic [PERIOD_W-1:0] r_fall_period;
    logic [HUE_W-1:0]    r_hue_low;
    logic [HUE_W-1:0]    r_hue_high;

    // Persistent state
    logic [HGT_W-1:0]    r_peak;
    logic [PERIOD_W-1:0] r_fall_cnt;

    // Datapath
    logic [DIFF_W-1:0]  r_ndiff;
    logic [DIFF_W-1:0]  r_ddiff;
    logic [LEVEL_W-1:0] r_a;
    logic [LEVEL_W-1:0] r_d;
    logic               r_zero;
    logic               r_sat;
    logic [HUE_W-1:0]   r_mplier;
    logic [ACC_W-1:0]   r_acc;
    logic [DSH_W-1:0]   r_dsh;
    logic [HGT_W-1:0]   r_qt;

    // Hue step division (|span| / (ROWS-1))
    logic               r_hneg;
    logic [HUE_W-1:0]   r_hdiv;
    logic [ROW_W-1:0]   r_hrem;

    // Row emission
    logic [HGT_W-1:0]   r_height;
    logic               r_dot_on;
    logic [ROW_W-1:0]   r_dot_row;
    logic [ROW_W-1:0]   r_row;
    logic [HUE_W-1:0]   r_hq;
    logic [ROW_W-1:0]   r_hr;

    logic               r_out_valid;
    t_out_beat          r_out;

    // Combinational helpers
    logic               accept;
    logic               load;
    logic               ge;
    logic [ACC_W-1:0]   dsh_ext;
    logic [ROW_W:0]     hstep_t;
    logic               hstep_ge;
    logic [HUE_W:0]     span;
    logic [HGT_W-1:0]   n_height;
    logic [HGT_W-1:0]   n_shown;
    logic [PERIOD_W-1:0] n_fall_cnt;
    logic               drop;
    logic [ROW_W:0]     hsum;
    logic               hcarry;
    logic [ROW_W-1:0]   n_hr;
    logic [HUE_W-1:0]   n_hq;
    logic               is_dot;
    logic [HUE_W-1:0]   q_sel;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign load        = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Divide step: trial subtract of the shifted divisor
    assign dsh_ext = {1'b0, r_dsh};
    assign ge      = (r_acc >= dsh_ext);

    // Hue step division: one dividend bit a cycle
    assign hstep_t  = {r_hrem, r_hdiv[HUE_W-1]};
    assign hstep_ge = (hstep_t >= {1'b0, DEN});

    assign span = {1'b0, r_hue_high} - {1'b0, r_hue_low};

    // Height clamp, peak rise and fall counter
    always_comb begin
        if (r_zero) begin
            n_height = '0;
        end else if (r_sat) begin
            n_height = r_full_scale;
        end else begin
            n_height = r_qt;
        end
        n_shown    = (n_height > r_peak) ? n_height : r_peak;
        n_fall_cnt = r_fall_cnt + 1'b1;
        drop       = (n_fall_cnt >= r_fall_period);
    end

    // Row gradient accumulator: Q += step, R += rem with one carry correction
    always_comb begin
        hsum   = {1'b0, r_hr} + {1'b0, r_hrem};
        hcarry = (hsum >= {1'b0, DEN});
        n_hr   = hcarry ? ROW_W'(hsum - {1'b0, DEN}) : hsum[ROW_W-1:0];
        n_hq   = r_hq + r_hdiv + {{(HUE_W-1){1'b0}}, hcarry};
        is_dot = r_dot_on && (r_row == r_dot_row);
        q_sel  = is_dot ? n_hq : r_hq;
    end

    // Sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_peak     <= '0;
            r_fall_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (drop) begin
                        r_peak     <= (n_shown != '0) ? n_shown - 1'b1 : n_shown;
                        r_fall_cnt <= '0;
                    end else begin
                        r_peak     <= n_shown;
                        r_fall_cnt <= n_fall_cnt;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load && (r_row == LAST_ROW)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale  <= FULL_SCALE_RST;
            r_fall_period <= FALL_PERIOD_RST;
            r_hue_low     <= HUE_LOW_RST;
            r_hue_high    <= HUE_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FULL_SCALE:  r_full_scale  <= i_cfg_data[HGT_W-1:0];
                REG_FALL_PERIOD: r_fall_period <= i_cfg_data[PERIOD_W-1:0];
                REG_HUE_LOW:     r_hue_low     <= i_cfg_data[HUE_W-1:0];
                REG_HUE_HIGH:    r_hue_high    <= i_cfg_data[HUE_W-1:0];
            endcase
        end
    end

    // Serial multiply, restoring divide and hue step division
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_ndiff <= {1'b0, i_in.data.level} - {1'b0, i_in.data.floor_level};
                    r_ddiff <= {1'b0, i_in.data.ceiling_level} - {1'b0, i_in.data.floor_level};
                end
            end
            S_ABS: begin
                // magnitudes; opposite signs or a zero span give height 0
                r_a      <= r_ndiff[DIFF_W-1] ? LEVEL_W'(-r_ndiff) : r_ndiff[LEVEL_W-1:0];
                r_d      <= r_ddiff[DIFF_W-1] ? LEVEL_W'(-r_ddiff) : r_ddiff[LEVEL_W-1:0];
                r_zero   <= (r_ndiff[DIFF_W-1] != r_ddiff[DIFF_W-1]) || (r_ddiff == '0);
                r_mplier <= {1'b0, r_full_scale};
                r_acc    <= '0;
                r_hneg   <= span[HUE_W];
                r_hdiv   <= span[HUE_W] ? HUE_W'(-span) : span[HUE_W-1:0];
                r_hrem   <= '0;
            end
            S_MUL: begin
                // MSB-first shift and add of full_scale * |level - floor|
                r_acc    <= {r_acc[ACC_W-2:0], 1'b0}
                            + (r_mplier[HUE_W-1] ? {{HGT_W{1'b0}}, r_a} : '0);
                r_mplier <= {r_mplier[HUE_W-2:0], 1'b0};
                // level span at least as large as the ceiling span saturates
                r_sat    <= (r_a >= r_d);
                r_hrem   <= hstep_ge ? ROW_W'(hstep_t - {1'b0, DEN}) : hstep_t[ROW_W-1:0];
                r_hdiv   <= {r_hdiv[HUE_W-2:0], hstep_ge};
                if (r_cnt == MUL_LAST) begin
                    r_dsh <= {r_d, {(HGT_W-1){1'b0}}};
                    r_qt  <= '0;
                end
            end
            S_DIV: begin
                // quotient below full_scale here, so seven bits suffice
                if (ge) begin
                    r_acc <= r_acc - dsh_ext;
                end
                r_qt  <= {r_qt[HGT_W-2:0], ge};
                r_dsh <= {1'b0, r_dsh[DSH_W-1:1]};
            end
            S_PEAK: begin
                r_height  <= n_height;
                r_dot_on  <= (n_shown > DOT_MIN) && (n_shown < ROWS_H);
                r_dot_row <= ROW_W'(n_shown - 1'b1);
                r_row     <= '0;
                r_hq      <= '0;
                r_hr      <= '0;
            end
            S_EMIT: begin
                if (load) begin
                    r_row <= r_row + 1'b1;
                    r_hq  <= n_hq;
                    r_hr  <= n_hr;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register, one row beat per load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.row        <= r_row;
            r_out.lit        <= ({1'b0, r_row} < r_height);
            r_out.hue        <= r_hneg ? r_hue_low - q_sel : r_hue_low + q_sel;
            r_out.peak_dot   <= is_dot;
            r_out.bar_height <= r_height;
            r_out.held_peak  <= r_peak;
            r_out.last_row   <= (r_row == LAST_ROW);
        end
    end

endmodule

`default_nettype wire
